### rtl/core/dual_ppm_frame_assembler_macros.svh
// assertion macros used by the frame assembler checker
`ifndef DUAL_PPM_FRAME_ASSEMBLER_MACROS_SVH
`define DUAL_PPM_FRAME_ASSEMBLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DPFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dpfa_pkg.sv
// shared constants, register codes and types of the dual ppm frame assembler
package dpfa_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int NUM_SOURCES  = 2;
  localparam int STORE_SLOTS  = 8;
  localparam int SLOT_W       = $clog2(STORE_SLOTS);
  localparam int IDX_W        = 4;
  localparam int CHAN_W       = 12;
  localparam int GAP_W        = 16;
  localparam int SEP_W        = 10;
  localparam int MINV_W       = 4;
  localparam int SUM_W        = GAP_W + 1;
  localparam int CFG_W        = 16;
  localparam int CFGI_W       = 3;

  localparam logic [CHAN_W-1:0] NEUTRAL_US    = CHAN_W'(1500);
  localparam logic [GAP_W-1:0]  RST_SYNC_THR  = GAP_W'(2500);
  localparam logic [SEP_W-1:0]  RST_SEPARATOR = SEP_W'(300);
  localparam logic [CHAN_W-1:0] RST_CLAMP_LO  = CHAN_W'(800);
  localparam logic [CHAN_W-1:0] RST_CLAMP_HI  = CHAN_W'(2200);
  localparam logic [MINV_W-1:0] RST_MIN_VALID = MINV_W'(4);

  // register indexes of the configuration port
  localparam logic [CFGI_W-1:0] REG_SYNC_THR  = CFGI_W'(0);
  localparam logic [CFGI_W-1:0] REG_SEPARATOR = CFGI_W'(1);
  localparam logic [CFGI_W-1:0] REG_CLAMP_LO  = CFGI_W'(2);
  localparam logic [CFGI_W-1:0] REG_CLAMP_HI  = CFGI_W'(3);
  localparam logic [CFGI_W-1:0] REG_MIN_VALID = CFGI_W'(4);

  typedef struct packed {
    logic [GAP_W-1:0]  sync_thr;
    logic [SEP_W-1:0]  separator;
    logic [CHAN_W-1:0] clamp_lo;
    logic [CHAN_W-1:0] clamp_hi;
    logic [MINV_W-1:0] min_valid;
  } cfg_t;

  // one classified item on its way to the back end
  typedef struct packed {
    logic              src;
    logic              sync;
    logic [CHAN_W-1:0] val;
  } op_t;

  typedef logic [STORE_SLOTS-1:0][CHAN_W-1:0] frame_t;
  typedef frame_t [NUM_SOURCES-1:0] pair_t;

endpackage

### rtl/core/dual_ppm_frame_assembler.sv
// top level of the dual ppm frame assembler
// Input channel: push with source_sel and gap_us; an item is taken when push is
// high and full is low. Each item is a measured gap of one of two ppm sources.
// Result channel: while empty is low the oldest result is on source_id, last and
// chan_0..chan_7; pop with empty low takes it. Results always come in pairs:
// source 0 with last low, then source 1 with last high.
// Configuration: cfg_we writes cfg_data to register cfg_index at the clock edge
// (0 sync threshold, 1 separator, 2 clamp low, 3 clamp high, 4 min channels).
// Path: with both queues empty, a pair reaches the result ports once the closing
// item has passed the command queue and the pair is written into the result queue.
// Throughput: one item per cycle into a 2-entry command queue while full is low;
// the back end applies one item per cycle while the 2-pair result queue has
// room, and a pair leaves as two results, source 0 then source 1.
// Reset (rst, synchronous): registers to defaults, store entries to 1500, slot
// indexes and fresh marks cleared, both queues emptied.
// When the receiver stalls, the result queue fills, the back end stops, and
// full rises once the command queue is full.
module dual_ppm_frame_assembler
  import dpfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              source_sel,
  input  logic [GAP_W-1:0]  gap_us,
  output logic              empty,
  input  logic              pop,
  output logic              source_id,
  output logic              last,
  output logic [CHAN_W-1:0] chan_0,
  output logic [CHAN_W-1:0] chan_1,
  output logic [CHAN_W-1:0] chan_2,
  output logic [CHAN_W-1:0] chan_3,
  output logic [CHAN_W-1:0] chan_4,
  output logic [CHAN_W-1:0] chan_5,
  output logic [CHAN_W-1:0] chan_6,
  output logic [CHAN_W-1:0] chan_7,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cfg_t   cfg;
  logic   q_full;
  logic   q_wr;
  op_t    q_op;
  logic   q_empty;
  logic   q_rd;
  op_t    q_rd_op;
  logic   pair_full;
  logic   pair_push;
  pair_t  pair_data;
  logic   half;
  frame_t frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_thr  <= RST_SYNC_THR;
      cfg.separator <= RST_SEPARATOR;
      cfg.clamp_lo  <= RST_CLAMP_LO;
      cfg.clamp_hi  <= RST_CLAMP_HI;
      cfg.min_valid <= RST_MIN_VALID;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_THR:  cfg.sync_thr  <= cfg_data;
        REG_SEPARATOR: cfg.separator <= cfg_data[SEP_W-1:0];
        REG_CLAMP_LO:  cfg.clamp_lo  <= cfg_data[CHAN_W-1:0];
        REG_CLAMP_HI:  cfg.clamp_hi  <= cfg_data[CHAN_W-1:0];
        REG_MIN_VALID: cfg.min_valid <= cfg_data[MINV_W-1:0];
        default: ;
      endcase
    end
  end

  dpfa_front u_front (
    .rst        (rst),
    .push       (push),
    .full       (full),
    .source_sel (source_sel),
    .gap_us     (gap_us),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_op       (q_op)
  );

  dpfa_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wr_op (q_op),
    .full  (q_full),
    .rd    (q_rd),
    .empty (q_empty),
    .rd_op (q_rd_op)
  );

  dpfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .min_valid (cfg.min_valid),
    .cmd_empty (q_empty),
    .cmd_op    (q_rd_op),
    .cmd_rd    (q_rd),
    .pair_full (pair_full),
    .pair_push (pair_push),
    .pair_data (pair_data)
  );

  dpfa_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (pair_push),
    .push_data (pair_data),
    .full      (pair_full),
    .empty     (empty),
    .pop       (pop),
    .half      (half),
    .frame     (frame)
  );

  assign source_id = half;
  assign last      = half;
  assign chan_0    = frame[0];
  assign chan_1    = frame[1];
  assign chan_2    = frame[2];
  assign chan_3    = frame[3];
  assign chan_4    = frame[4];
  assign chan_5    = frame[5];
  assign chan_6    = frame[6];
  assign chan_7    = frame[7];

endmodule

### rtl/core/dpfa_front.sv
// front end: classifies each gap as sync or channel and clamps the channel value
module dpfa_front
  import dpfa_pkg::*;
(
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             source_sel,
  input  logic [GAP_W-1:0] gap_us,
  input  cfg_t             cfg,
  input  logic             q_full,
  output logic             q_wr,
  output op_t              q_op
);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] raised;
  logic [SUM_W-1:0] lowered;

  always_comb begin
    sum = SUM_W'(gap_us) + SUM_W'(cfg.separator);
    raised = (sum < SUM_W'(cfg.clamp_lo)) ? SUM_W'(cfg.clamp_lo) : sum;
    // crossed bounds end up at clamp_hi, as the upper clamp comes last
    lowered = (raised > SUM_W'(cfg.clamp_hi)) ? SUM_W'(cfg.clamp_hi) : raised;
  end

  assign full = q_full;
  assign q_wr = push && !q_full && !rst;
  assign q_op = '{src: source_sel, sync: (gap_us > cfg.sync_thr),
                  val: lowered[CHAN_W-1:0]};

endmodule

### rtl/core/dpfa_cmdq.sv
// two-entry queue of classified items between front and back end
module dpfa_cmdq
  import dpfa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  op_t  wr_op,
  output logic full,
  input  logic rd,
  output logic empty,
  output op_t  rd_op
);

  op_t        entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rd_op = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry[wp] <= wr_op;
    end
  end

endmodule

### rtl/core/dpfa_back.sv
// back end: keeps slot indexes, channel store and fresh marks, hands out frame pairs
module dpfa_back
  import dpfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [MINV_W-1:0] min_valid,
  input  logic              cmd_empty,
  input  op_t               cmd_op,
  output logic              cmd_rd,
  input  logic              pair_full,
  output logic              pair_push,
  output pair_t             pair_data
);

  frame_t                 store    [NUM_SOURCES];
  logic [IDX_W-1:0]       slot_idx [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] fresh;
  logic [NUM_SOURCES-1:0] fresh_next;
  logic [IDX_W-1:0]       cur_idx;
  logic                   end_frame;

  // only take an item when a whole pair could still be queued
  assign cmd_rd = !cmd_empty && !pair_full;

  always_comb begin
    cur_idx    = slot_idx[cmd_op.src];
    end_frame  = cmd_op.sync || (cur_idx >= IDX_W'(NUM_CHANNELS));
    fresh_next = fresh;
    if (cmd_rd && end_frame && (cur_idx >= IDX_W'(min_valid))) begin
      fresh_next[cmd_op.src] = 1'b1;
    end
    pair_push = cmd_rd && (&fresh_next);
  end

  // a pair only completes on a frame-ending item, so the store is unchanged this cycle
  always_comb begin
    for (int s = 0; s < NUM_SOURCES; s++) begin
      pair_data[s] = store[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= '0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        slot_idx[s] <= '0;
        for (int c = 0; c < STORE_SLOTS; c++) begin
          store[s][c] <= NEUTRAL_US;
        end
      end
    end else begin
      fresh <= pair_push ? '0 : fresh_next;
      if (cmd_rd) begin
        if (end_frame) begin
          slot_idx[cmd_op.src] <= '0;
        end else begin
          store[cmd_op.src][cur_idx[SLOT_W-1:0]] <= cmd_op.val;
          slot_idx[cmd_op.src] <= cur_idx + IDX_W'(1);
        end
      end
    end
  end

endmodule

### rtl/core/dpfa_outq.sv
// result queue of frame pairs, shown as source 0 then source 1
module dpfa_outq
  import dpfa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  pair_t  push_data,
  output logic   full,
  output logic   empty,
  input  logic   pop,
  output logic   half,
  output frame_t frame
);

  pair_t      entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       pop_ok;
  logic       retire;

  assign full   = (cnt == 2'd2);
  assign empty  = (cnt == 2'd0);
  assign pop_ok = pop && !empty;
  assign retire = pop_ok && half;
  assign frame  = entry[rp][half];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      cnt  <= 2'd0;
      half <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop_ok) begin
        half <= ~half;
      end
      if (retire) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(retire);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= push_data;
    end
  end

endmodule

### rtl/core/dpfa_checker.sv
// port-level checks of the frame assembler result channel, bound to the top level
`include "dual_ppm_frame_assembler_macros.svh"

module dpfa_checker
  import dpfa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input logic              source_id,
  input logic              last,
  input logic [CHAN_W-1:0] chan_0
);

  // nothing waits right after reset
  `DPFA_ASSERT_NOW(a_empty_after_rst, $past(rst), empty, "result shown right after reset")

  // source 1 always closes the pair
  `DPFA_ASSERT_NOW(a_src_is_last, !empty, source_id == last, "source_id and last disagree")

  // taking the first half leaves the second half waiting
  `DPFA_ASSERT_NEXT(a_pair_whole, pop && !empty && !last, !empty && source_id && last,
    "second item of a pair missing")

  // a stalled item holds
  `DPFA_ASSERT_NEXT(a_stall_hold, !empty && !pop,
    !empty && $stable(source_id) && $stable(chan_0), "stalled item changed")

endmodule

bind dual_ppm_frame_assembler dpfa_checker u_dpfa_checker (.*);

### tb/sv/tb_dual_ppm_frame_assembler.sv
// self-checking testbench of the dual ppm frame assembler with a frame-pair predictor
module tb_dual_ppm_frame_assembler;
  import dpfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct {
    logic   src;
    logic   last;
    frame_t chans;
  } ppm_frame_t;

  // predicts the frame pairs from the accepted gaps and compares the results
  class frame_pair_predictor;
    logic [GAP_W-1:0]  sync_thr;
    logic [SEP_W-1:0]  separator;
    logic [CHAN_W-1:0] clamp_lo;
    logic [CHAN_W-1:0] clamp_hi;
    logic [MINV_W-1:0] min_valid;
    frame_t            store [NUM_SOURCES];
    logic [IDX_W-1:0]  slot [NUM_SOURCES];
    logic              fresh [NUM_SOURCES];
    ppm_frame_t        awaited_frames [$];
    int                errors;
    int                frames_compared;

    function new();
      sync_thr  = RST_SYNC_THR;
      separator = RST_SEPARATOR;
      clamp_lo  = RST_CLAMP_LO;
      clamp_hi  = RST_CLAMP_HI;
      min_valid = RST_MIN_VALID;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        for (int c = 0; c < STORE_SLOTS; c++) store[s][c] = NEUTRAL_US;
        slot[s]  = '0;
        fresh[s] = 1'b0;
      end
      errors = 0;
      frames_compared = 0;
    endfunction

    function void set_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SYNC_THR:  sync_thr  = data[GAP_W-1:0];
        REG_SEPARATOR: separator = data[SEP_W-1:0];
        REG_CLAMP_LO:  clamp_lo  = data[CHAN_W-1:0];
        REG_CLAMP_HI:  clamp_hi  = data[CHAN_W-1:0];
        REG_MIN_VALID: min_valid = data[MINV_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_gap(logic src, logic [GAP_W-1:0] gap);
      logic [IDX_W-1:0] idx;
      logic [SUM_W-1:0] sum;
      idx = slot[src];
      if (gap > sync_thr || idx >= NUM_CHANNELS) begin
        if (idx >= min_valid) fresh[src] = 1'b1;
        slot[src] = '0;
      end else begin
        // sum kept one bit wider so large gaps clamp rather than wrap
        sum = SUM_W'(gap) + SUM_W'(separator);
        if (sum < SUM_W'(clamp_lo)) sum = SUM_W'(clamp_lo);
        if (sum > SUM_W'(clamp_hi)) sum = SUM_W'(clamp_hi);
        store[src][idx[SLOT_W-1:0]] = sum[CHAN_W-1:0];
        slot[src] = idx + 1'b1;
      end
      if (fresh[0] && fresh[1]) begin
        fresh[0] = 1'b0;
        fresh[1] = 1'b0;
        awaited_frames.push_back('{1'b0, 1'b0, store[0]});
        awaited_frames.push_back('{1'b1, 1'b1, store[1]});
      end
    endfunction

    function void compare_frame(logic src, logic lst, frame_t chans);
      ppm_frame_t want;
      if (awaited_frames.size() == 0) begin
        $display("%0t: unexpected frame: source_id %0d last %0d", $time, src, lst);
        errors++;
        return;
      end
      want = awaited_frames.pop_front();
      frames_compared++;
      if (src !== want.src) begin
        $display("%0t: source_id expected %0d actual %0d", $time, want.src, src);
        errors++;
      end
      if (lst !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, lst);
        errors++;
      end
      for (int c = 0; c < STORE_SLOTS; c++) begin
        if (chans[c] !== want.chans[c]) begin
          $display("%0t: chan_%0d expected %0d actual %0d", $time, c, want.chans[c], chans[c]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return awaited_frames.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic              source_sel = 1'b0;
  logic [GAP_W-1:0]  gap_us = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              source_id;
  logic              last;
  logic [CHAN_W-1:0] chan_0, chan_1, chan_2, chan_3, chan_4, chan_5, chan_6, chan_7;
  logic              cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  frame_pair_predictor model;
  int idle_pct = 0;
  int stall_pct = 0;
  int gaps_sent = 0;
  int settings_written = 0;
  int quiet_cycles = 0;
  int frame_target [NUM_SOURCES];

  dual_ppm_frame_assembler i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .source_sel (source_sel),
    .gap_us     (gap_us),
    .empty      (empty),
    .pop        (pop),
    .source_id  (source_id),
    .last       (last),
    .chan_0     (chan_0),
    .chan_1     (chan_1),
    .chan_2     (chan_2),
    .chan_3     (chan_3),
    .chan_4     (chan_4),
    .chan_5     (chan_5),
    .chan_6     (chan_6),
    .chan_7     (chan_7),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // frame receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        model.compare_frame(source_id, last,
                            {chan_7, chan_6, chan_5, chan_4, chan_3, chan_2, chan_1, chan_0});
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("dual_ppm_frame_assembler: mismatch");
        $finish;
      end
    end
  end

  task automatic send_gap(input logic s, input logic [GAP_W-1:0] g);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    source_sel <= s;
    gap_us     <= g;
    @(posedge clk);
    while (full) @(posedge clk);
    model.take_gap(s, g);
    gaps_sent++;
  endtask

  // hold the sender until every frame is out and the command queue has drained
  task automatic settle();
    push <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // channels to send before closing a frame, mostly enough to make it fresh
  function automatic int pick_target();
    int floor_n;
    if (model.sync_thr == {GAP_W{1'b1}}) return NUM_CHANNELS;
    floor_n = (model.min_valid <= NUM_CHANNELS && $urandom_range(3) != 0) ? model.min_valid : 0;
    return $urandom_range(NUM_CHANNELS, floor_n);
  endfunction

  function automatic logic [GAP_W-1:0] channel_gap();
    case ($urandom_range(7))
      0: return '0;
      1: return model.sync_thr;
      default: return GAP_W'($urandom_range(model.sync_thr, 0));
    endcase
  endfunction

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    model.set_reg(idx, data);
  endtask

  task automatic write_settings(input logic [GAP_W-1:0] thr, input logic [SEP_W-1:0] sep,
                                input logic [CHAN_W-1:0] lo, input logic [CHAN_W-1:0] hi,
                                input logic [MINV_W-1:0] minv, input bit spare);
    write_reg(REG_SYNC_THR, CFG_W'(thr));
    write_reg(REG_SEPARATOR, CFG_W'(sep));
    write_reg(REG_CLAMP_LO, CFG_W'(lo));
    write_reg(REG_CLAMP_HI, CFG_W'(hi));
    write_reg(REG_MIN_VALID, CFG_W'(minv));
    // indexes past the last register must leave the settings alone
    if (spare)
      for (int i = REG_MIN_VALID + 1; i < 2**CFGI_W; i++)
        write_reg(CFGI_W'(i), CFG_W'($urandom));
    cfg_we <= 1'b0;
    settings_written++;
    for (int s = 0; s < NUM_SOURCES; s++) frame_target[s] = pick_target();
  endtask

  task automatic random_settings();
    logic [GAP_W-1:0]  thr;
    logic [CHAN_W-1:0] lo;
    thr = ($urandom_range(3) == 0) ? GAP_W'($urandom_range(65535))
                                   : GAP_W'($urandom_range(4000, 1000));
    lo  = CHAN_W'($urandom_range(1500));
    write_settings(thr, SEP_W'($urandom_range(1023)), lo,
                   CHAN_W'($urandom_range(4095, lo)), MINV_W'($urandom_range(NUM_CHANNELS)),
                   $urandom_range(1));
  endtask

  task automatic send_frames(input int count);
    logic             s;
    logic [GAP_W-1:0] g;
    bit               closing;
    for (int n = 0; n < count; n++) begin
      s = $urandom_range(1);
      closing = 1'b0;
      if ($urandom_range(99) < 12) begin
        g = GAP_W'($urandom_range(65535));
      end else if (model.slot[s] < frame_target[s]) begin
        g = channel_gap();
      end else begin
        closing = 1'b1;
        // full slots close the frame even on a short gap
        if (model.slot[s] >= NUM_CHANNELS &&
            (model.sync_thr == {GAP_W{1'b1}} || $urandom_range(1) == 1))
          g = channel_gap();
        else if (model.sync_thr == {GAP_W{1'b1}})
          g = channel_gap();
        else
          g = GAP_W'($urandom_range(65535, int'(model.sync_thr) + 1));
      end
      send_gap(s, g);
      if (closing) frame_target[s] = pick_target();
    end
  endtask

  initial begin
    model = new();
    for (int s = 0; s < NUM_SOURCES; s++) frame_target[s] = NUM_CHANNELS;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    idle_pct  = 11;
    stall_pct = 11;

    // source 0: clamp from below and above, gap equal to threshold is a channel
    send_gap(1'b0, 16'd0);
    send_gap(1'b0, 16'd500);
    send_gap(1'b0, 16'd1900);
    send_gap(1'b0, 16'd2500);
    send_gap(1'b0, 16'd2501);
    // source 1: short frame stays stale, then a full frame closed by slot overflow
    send_gap(1'b1, 16'd1200);
    send_gap(1'b1, 16'd1200);
    send_gap(1'b1, 16'd1200);
    send_gap(1'b1, 16'hFFFF);
    for (int c = 0; c < NUM_CHANNELS; c++) send_gap(1'b1, GAP_W'(100 + 300 * c));
    send_gap(1'b1, 16'd100);

    send_frames(140);
    settle();
    send_frames(50);
    settle();

    // crossed bounds and widest sum; only slot overflow can close a frame
    write_settings(16'hFFFF, 10'h3FF, 12'hFFF, 12'h000, 4'd0, 1'b0);
    send_gap(1'b0, 16'hFFFF);
    send_frames(100);
    settle();

    // zero minimum: a sync with no channels still makes a fresh frame
    write_settings(16'd0, 10'd0, 12'd0, 12'hFFF, 4'd0, 1'b0);
    send_gap(1'b0, 16'd1);
    send_gap(1'b1, 16'hFFFF);
    send_frames(80);
    settle();

    // minimum out of reach: no frame may come out
    write_settings(RST_SYNC_THR, RST_SEPARATOR, RST_CLAMP_LO, RST_CLAMP_HI, 4'hF, 1'b1);
    send_frames(40);
    settle();
    write_settings(16'd3000, 10'd500, 12'd1000, 12'd2000, 4'd9, 1'b1);
    send_frames(20);
    settle();

    idle_pct  = 0;
    stall_pct = 0;
    random_settings();
    send_frames(150);
    settle();
    idle_pct  = 11;
    stall_pct = 11;

    repeat (3) begin
      random_settings();
      send_frames(60);
      settle();
    end

    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d gaps under %0d register settings, compared %0d frames",
             gaps_sent, settings_written + 1, model.frames_compared);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("dual_ppm_frame_assembler: match");
    end else begin
      $display("%0d errors, %0d frames still awaited", model.errors, model.pending());
      $display("dual_ppm_frame_assembler: mismatch");
    end
    $finish;
  end

endmodule
